// ===== rtl/stt_pkg.sv =====
package stt_pkg;

   localparam int OffsetWidth = 32;
   localparam int LengthWidth = 16;
   localparam int LineWidth   = 24;
   localparam int KindWidth   = 7;
   localparam int WordDepth   = 9;

   localparam logic [KindWidth-1:0] K_ID         = 7'd0;
   localparam logic [KindWidth-1:0] K_AS         = 7'd1;
   localparam logic [KindWidth-1:0] K_DEF        = 7'd2;
   localparam logic [KindWidth-1:0] K_ENUM       = 7'd3;
   localparam logic [KindWidth-1:0] K_ELSE       = 7'd4;
   localparam logic [KindWidth-1:0] K_WIDTHWORD  = 7'd5;
   localparam logic [KindWidth-1:0] K_FALSE      = 7'd6;
   localparam logic [KindWidth-1:0] K_FORM       = 7'd7;
   localparam logic [KindWidth-1:0] K_GLOBAL     = 7'd8;
   localparam logic [KindWidth-1:0] K_INCLUDE    = 7'd9;
   localparam logic [KindWidth-1:0] K_LOG        = 7'd10;
   localparam logic [KindWidth-1:0] K_NONE       = 7'd11;
   localparam logic [KindWidth-1:0] K_OP         = 7'd12;
   localparam logic [KindWidth-1:0] K_OR         = 7'd13;
   localparam logic [KindWidth-1:0] K_OBJ        = 7'd14;
   localparam logic [KindWidth-1:0] K_PARENT     = 7'd15;
   localparam logic [KindWidth-1:0] K_PAIR       = 7'd16;
   localparam logic [KindWidth-1:0] K_PILOT      = 7'd17;
   localparam logic [KindWidth-1:0] K_PRIVATE    = 7'd18;
   localparam logic [KindWidth-1:0] K_PUBLIC     = 7'd19;
   localparam logic [KindWidth-1:0] K_RETURN     = 7'd20;
   localparam logic [KindWidth-1:0] K_SELF       = 7'd21;
   localparam logic [KindWidth-1:0] K_THIS       = 7'd22;
   localparam logic [KindWidth-1:0] K_TRUE       = 7'd23;
   localparam logic [KindWidth-1:0] K_WHEN       = 7'd24;
   localparam logic [KindWidth-1:0] K_WHILE      = 7'd25;
   localparam logic [KindWidth-1:0] K_WRITE      = 7'd26;
   localparam logic [KindWidth-1:0] K_BIN        = 7'd27;
   localparam logic [KindWidth-1:0] K_OCT        = 7'd28;
   localparam logic [KindWidth-1:0] K_HEX        = 7'd29;
   localparam logic [KindWidth-1:0] K_DECIMAL    = 7'd30;
   localparam logic [KindWidth-1:0] K_STR        = 7'd31;
   localparam logic [KindWidth-1:0] K_LPAREN     = 7'd32;
   localparam logic [KindWidth-1:0] K_RPAREN     = 7'd33;
   localparam logic [KindWidth-1:0] K_LSQ        = 7'd34;
   localparam logic [KindWidth-1:0] K_RSQ        = 7'd35;
   localparam logic [KindWidth-1:0] K_LCURL      = 7'd36;
   localparam logic [KindWidth-1:0] K_RCURL      = 7'd37;
   localparam logic [KindWidth-1:0] K_DOT        = 7'd38;
   localparam logic [KindWidth-1:0] K_COMMA      = 7'd39;
   localparam logic [KindWidth-1:0] K_DCOLON     = 7'd40;
   localparam logic [KindWidth-1:0] K_COLON      = 7'd41;
   localparam logic [KindWidth-1:0] K_PLUSPLUS   = 7'd42;
   localparam logic [KindWidth-1:0] K_PLUSSET    = 7'd43;
   localparam logic [KindWidth-1:0] K_ADD        = 7'd44;
   localparam logic [KindWidth-1:0] K_ARROW      = 7'd45;
   localparam logic [KindWidth-1:0] K_MINUSMINUS = 7'd46;
   localparam logic [KindWidth-1:0] K_MINUSSET   = 7'd47;
   localparam logic [KindWidth-1:0] K_SUB        = 7'd48;
   localparam logic [KindWidth-1:0] K_ASTER      = 7'd49;
   localparam logic [KindWidth-1:0] K_SLASH      = 7'd50;
   localparam logic [KindWidth-1:0] K_PERCENT    = 7'd51;
   localparam logic [KindWidth-1:0] K_UNDERSCORE = 7'd52;
   localparam logic [KindWidth-1:0] K_QMARK      = 7'd53;
   localparam logic [KindWidth-1:0] K_DOLLAR     = 7'd54;
   localparam logic [KindWidth-1:0] K_CARET      = 7'd55;
   localparam logic [KindWidth-1:0] K_NOTEQ      = 7'd56;
   localparam logic [KindWidth-1:0] K_BANG       = 7'd57;
   localparam logic [KindWidth-1:0] K_EQUALS2    = 7'd58;
   localparam logic [KindWidth-1:0] K_EQUALS     = 7'd59;
   localparam logic [KindWidth-1:0] K_LESSEQ     = 7'd60;
   localparam logic [KindWidth-1:0] K_LARROW     = 7'd61;
   localparam logic [KindWidth-1:0] K_LESS       = 7'd62;
   localparam logic [KindWidth-1:0] K_MOREEQ     = 7'd63;
   localparam logic [KindWidth-1:0] K_MORE       = 7'd64;
   localparam logic [KindWidth-1:0] K_AT         = 7'd65;
   localparam logic [KindWidth-1:0] K_AMP2       = 7'd66;
   localparam logic [KindWidth-1:0] K_AMP        = 7'd67;
   localparam logic [KindWidth-1:0] K_PIPE2      = 7'd68;
   localparam logic [KindWidth-1:0] K_PIPE       = 7'd69;
   localparam logic [KindWidth-1:0] K_END        = 7'd70;
   localparam logic [KindWidth-1:0] K_ERR_STR    = 7'd71;
   localparam logic [KindWidth-1:0] K_ERR_CHAR   = 7'd72;

   typedef enum logic [15:0] {
      M_IDLE      = 16'h0001,
      M_SLASH     = 16'h0002,
      M_LINECMT   = 16'h0004,
      M_BLOCK     = 16'h0008,
      M_BLOCKSTAR = 16'h0010,
      M_WORD      = 16'h0020,
      M_UNDER     = 16'h0040,
      M_ZERO      = 16'h0080,
      M_RBIN      = 16'h0100,
      M_ROCT      = 16'h0200,
      M_RHEX      = 16'h0400,
      M_DEC       = 16'h0800,
      M_DECDOT    = 16'h1000,
      M_FRAC      = 16'h2000,
      M_STRING    = 16'h4000,
      M_OPER      = 16'h8000
   } mode_type;

   // one emitted token, before the queue
   typedef struct packed {
      logic [KindWidth-1:0]   kind;
      logic [OffsetWidth-1:0] start;
      logic [LengthWidth-1:0] length;
      logic [LineWidth-1:0]   line;
      logic                   last;
   } token_type;

   // front to back: up to three tokens made by one byte
   typedef struct packed {
      logic [1:0] count;
      token_type  t0;
      token_type  t1;
      token_type  t2;
   } batch_type;

   localparam int BatchWidth = $bits(batch_type);

   typedef logic [8*WordDepth-1:0] chars_type;

   function automatic logic [7:0] ch(input chars_type w, input int i);
      return w[8*i +: 8];
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hexdig(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // compares the first n buffered chars against a literal (low char first)
   function automatic logic word_is(input chars_type w, input logic [LengthWidth-1:0] n,
                                    input logic [8*WordDepth-1:0] s, input int sz);
      logic ok;
      ok = (n == LengthWidth'(sz));
      for (int i = 0; i < WordDepth; i++) begin
         if (i < sz && ch(w, i) != s[8*(sz-1-i) +: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [KindWidth-1:0] word_kind(input chars_type w,
                                                     input logic [LengthWidth-1:0] n);
      logic [KindWidth-1:0] k;
      k = K_ID;
      if (word_is(w, n, "as", 2)) k = K_AS;
      if (word_is(w, n, "def", 3) || word_is(w, n, "define", 6)) k = K_DEF;
      if (word_is(w, n, "enum", 4)) k = K_ENUM;
      if (word_is(w, n, "else", 4)) k = K_ELSE;
      if (word_is(w, n, "u8", 2) || word_is(w, n, "i8", 2) || word_is(w, n, "u16", 3) ||
          word_is(w, n, "u32", 3) || word_is(w, n, "u64", 3) || word_is(w, n, "i16", 3) ||
          word_is(w, n, "i32", 3) || word_is(w, n, "i64", 3) || word_is(w, n, "f32", 3) ||
          word_is(w, n, "f64", 3)) k = K_WIDTHWORD;
      if (word_is(w, n, "false", 5)) k = K_FALSE;
      if (word_is(w, n, "form", 4)) k = K_FORM;
      if (word_is(w, n, "global", 6)) k = K_GLOBAL;
      if (word_is(w, n, "include", 7)) k = K_INCLUDE;
      if (word_is(w, n, "log", 3)) k = K_LOG;
      if (word_is(w, n, "none", 4) || word_is(w, n, "NONE", 4)) k = K_NONE;
      if (word_is(w, n, "op", 2) || word_is(w, n, "operation", 9)) k = K_OP;
      if (word_is(w, n, "or", 2)) k = K_OR;
      if (word_is(w, n, "obj", 3) || word_is(w, n, "object", 6)) k = K_OBJ;
      if (word_is(w, n, "parent", 6)) k = K_PARENT;
      if (word_is(w, n, "pair", 4)) k = K_PAIR;
      if (word_is(w, n, "pilot", 5)) k = K_PILOT;
      if (word_is(w, n, "private", 7)) k = K_PRIVATE;
      if (word_is(w, n, "public", 6)) k = K_PUBLIC;
      if (word_is(w, n, "return", 6)) k = K_RETURN;
      if (word_is(w, n, "self", 4)) k = K_SELF;
      if (word_is(w, n, "this", 4)) k = K_THIS;
      if (word_is(w, n, "true", 4)) k = K_TRUE;
      if (word_is(w, n, "when", 4)) k = K_WHEN;
      if (word_is(w, n, "while", 5)) k = K_WHILE;
      if (word_is(w, n, "write", 5)) k = K_WRITE;
      return k;
   endfunction

   // two-char operator, valid flag in the top bit
   function automatic logic [KindWidth:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
      logic [KindWidth:0] r;
      r = '0;
      unique case (h)
         ":": if (c == ":") r = {1'b1, K_DCOLON};
         "+": begin
            if (c == "+") r = {1'b1, K_PLUSPLUS};
            else if (c == "=") r = {1'b1, K_PLUSSET};
         end
         "-": begin
            if (c == ">") r = {1'b1, K_ARROW};
            else if (c == "-") r = {1'b1, K_MINUSMINUS};
            else if (c == "=") r = {1'b1, K_MINUSSET};
         end
         "!": if (c == "=") r = {1'b1, K_NOTEQ};
         "=": if (c == "=") r = {1'b1, K_EQUALS2};
         "<": begin
            if (c == "=") r = {1'b1, K_LESSEQ};
            else if (c == "-") r = {1'b1, K_LARROW};
         end
         ">": if (c == "=") r = {1'b1, K_MOREEQ};
         "&": if (c == "&") r = {1'b1, K_AMP2};
         "|": if (c == "|") r = {1'b1, K_PIPE2};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [KindWidth-1:0] lone_kind(input logic [7:0] h);
      logic [KindWidth-1:0] r;
      unique case (h)
         ":": r = K_COLON;
         "+": r = K_ADD;
         "-": r = K_SUB;
         "!": r = K_BANG;
         "=": r = K_EQUALS;
         "<": r = K_LESS;
         ">": r = K_MORE;
         "&": r = K_AMP;
         "|": r = K_PIPE;
         default: r = K_ERR_CHAR;
      endcase
      return r;
   endfunction

   function automatic logic [KindWidth:0] single_kind(input logic [7:0] c);
      logic [KindWidth:0] r;
      unique case (c)
         "(": r = {1'b1, K_LPAREN};
         ")": r = {1'b1, K_RPAREN};
         "[": r = {1'b1, K_LSQ};
         "]": r = {1'b1, K_RSQ};
         "{": r = {1'b1, K_LCURL};
         "}": r = {1'b1, K_RCURL};
         ".": r = {1'b1, K_DOT};
         ",": r = {1'b1, K_COMMA};
         "*": r = {1'b1, K_ASTER};
         "%": r = {1'b1, K_PERCENT};
         "?": r = {1'b1, K_QMARK};
         "$": r = {1'b1, K_DOLLAR};
         "^": r = {1'b1, K_CARET};
         "@": r = {1'b1, K_AT};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/stt_scan.sv =====
// front end: scanner state and token classification, one byte per cycle while step is high
module stt_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          text_byte,
   input  logic                end_of_text,
   output stt_pkg::batch_type  batch
);

   localparam logic [stt_pkg::OffsetWidth-1:0] OffMax = '1;
   localparam logic [stt_pkg::LengthWidth-1:0] LenMax = '1;
   localparam logic [stt_pkg::LineWidth-1:0]   LineMax = '1;

   stt_pkg::mode_type                  mode_ff, mode_in;
   logic [stt_pkg::OffsetWidth-1:0]    begin_ff, begin_in;
   logic [stt_pkg::OffsetWidth-1:0]    pos_ff, pos_in;
   logic [stt_pkg::LengthWidth-1:0]    len_ff, len_in;
   logic [stt_pkg::LineWidth-1:0]      line_ff, line_in;
   stt_pkg::chars_type                 chars_ff, chars_in;
   logic [7:0]                         held_ff, held_in;
   logic                               dquote_ff, dquote_in;
   logic                               esc_ff, esc_in;

   function automatic logic [stt_pkg::LengthWidth-1:0] linc(
      input logic [stt_pkg::LengthWidth-1:0] v);
      return (v == LenMax) ? v : v + 1'b1;
   endfunction

   always_comb begin
      logic [7:0]                      c;
      logic                            fin;
      logic                            again;
      logic [1:0]                      n;
      stt_pkg::token_type              tk [3];
      logic [stt_pkg::KindWidth:0]     pk;
      logic [stt_pkg::KindWidth:0]     sk;
      logic [stt_pkg::OffsetWidth-1:0] dot_off;
      logic [stt_pkg::OffsetWidth-1:0] nxt;

      c = text_byte;
      fin = end_of_text || (c == 8'd0);
      mode_in = mode_ff;
      begin_in = begin_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      line_in = line_ff;
      chars_in = chars_ff;
      held_in = held_ff;
      dquote_in = dquote_ff;
      esc_in = esc_ff;
      n = 2'd0;
      for (int i = 0; i < 3; i++) tk[i] = '0;
      again = 1'b0;
      pk = stt_pkg::pair_kind(held_ff, c);
      sk = stt_pkg::single_kind(c);
      dot_off = (pos_ff == OffMax || pos_ff == '0) ? pos_ff : pos_ff - 1'b1;
      nxt = (pos_ff == OffMax) ? pos_ff : pos_ff + 1'b1;

      if (fin) begin
         unique case (mode_ff)
            stt_pkg::M_SLASH: begin
               tk[0] = '{stt_pkg::K_SLASH, begin_ff, 1, line_ff, 1'b0}; n = 2'd1;
            end
            stt_pkg::M_UNDER: begin
               tk[0] = '{stt_pkg::K_UNDERSCORE, begin_ff, 1, line_ff, 1'b0}; n = 2'd1;
            end
            stt_pkg::M_WORD: begin
               tk[0] = '{stt_pkg::word_kind(chars_ff, len_ff), begin_ff, len_ff, line_ff, 1'b0};
               n = 2'd1;
            end
            stt_pkg::M_ZERO, stt_pkg::M_DEC, stt_pkg::M_FRAC: begin
               tk[0] = '{stt_pkg::K_DECIMAL, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
            end
            stt_pkg::M_RBIN: begin
               tk[0] = '{stt_pkg::K_BIN, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
            end
            stt_pkg::M_ROCT: begin
               tk[0] = '{stt_pkg::K_OCT, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
            end
            stt_pkg::M_RHEX: begin
               tk[0] = '{stt_pkg::K_HEX, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
            end
            stt_pkg::M_DECDOT: begin
               tk[0] = '{stt_pkg::K_DECIMAL, begin_ff, len_ff, line_ff, 1'b0};
               tk[1] = '{stt_pkg::K_DOT, dot_off, 1, line_ff, 1'b0};
               n = 2'd2;
            end
            stt_pkg::M_STRING: begin
               tk[0] = '{stt_pkg::K_ERR_STR, begin_ff, 0, line_ff, 1'b0}; n = 2'd1;
            end
            stt_pkg::M_OPER: begin
               tk[0] = '{stt_pkg::lone_kind(held_ff), begin_ff, 1, line_ff, 1'b0}; n = 2'd1;
            end
            default: n = 2'd0;
         endcase
         tk[n] = '{stt_pkg::K_END, pos_ff, 0, line_ff, 1'b0};
         n = n + 2'd1;
         mode_in = stt_pkg::M_IDLE;
         begin_in = '0;
         pos_in = '0;
         len_in = '0;
         line_in = stt_pkg::LineWidth'(1);
         held_in = '0;
         dquote_in = 1'b0;
         esc_in = 1'b0;
      end else begin
         pos_in = nxt;
         // first pass: continue the pending token; again means rescan from idle
         unique case (mode_ff)
            stt_pkg::M_SLASH: begin
               if (c == "/") mode_in = stt_pkg::M_LINECMT;
               else if (c == "*") mode_in = stt_pkg::M_BLOCK;
               else begin
                  tk[0] = '{stt_pkg::K_SLASH, begin_ff, 1, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_LINECMT: begin
               if (c == "\n") begin
                  line_in = (line_ff == LineMax) ? line_ff : line_ff + 1'b1;
                  mode_in = stt_pkg::M_IDLE;
               end
            end
            stt_pkg::M_BLOCK, stt_pkg::M_BLOCKSTAR: begin
               if (c == "/" && mode_ff == stt_pkg::M_BLOCKSTAR) mode_in = stt_pkg::M_IDLE;
               else begin
                  if (c == "\n") line_in = (line_ff == LineMax) ? line_ff : line_ff + 1'b1;
                  mode_in = (c == "*") ? stt_pkg::M_BLOCKSTAR : stt_pkg::M_BLOCK;
               end
            end
            stt_pkg::M_UNDER, stt_pkg::M_WORD: begin
               if (stt_pkg::is_letter(c) || c == "_" ||
                   (mode_ff == stt_pkg::M_WORD && stt_pkg::is_digit(c))) begin
                  // an underscore run switches to word and takes this char as well
                  for (int i = 1; i < stt_pkg::WordDepth; i++) begin
                     if (len_ff == stt_pkg::LengthWidth'(i)) chars_in[8*i +: 8] = c;
                  end
                  len_in = linc(len_ff);
                  mode_in = stt_pkg::M_WORD;
               end else if (mode_ff == stt_pkg::M_UNDER) begin
                  tk[0] = '{stt_pkg::K_UNDERSCORE, begin_ff, 1, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end else begin
                  tk[0] = '{stt_pkg::word_kind(chars_ff, len_ff), begin_ff, len_ff,
                            line_ff, 1'b0};
                  n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_ZERO: begin
               if (c == "b" || c == "c" || c == "x") begin
                  mode_in = (c == "b") ? stt_pkg::M_RBIN :
                            (c == "c") ? stt_pkg::M_ROCT : stt_pkg::M_RHEX;
                  begin_in = nxt;
                  len_in = '0;
               end else if (stt_pkg::is_digit(c)) begin
                  len_in = linc(len_ff);
                  mode_in = stt_pkg::M_DEC;
               end else if (c == ".") begin
                  mode_in = stt_pkg::M_DECDOT;
               end else begin
                  tk[0] = '{stt_pkg::K_DECIMAL, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_RBIN: begin
               if (c == "0" || c == "1") len_in = linc(len_ff);
               else begin
                  tk[0] = '{stt_pkg::K_BIN, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_ROCT: begin
               if (c >= "0" && c <= "7") len_in = linc(len_ff);
               else begin
                  tk[0] = '{stt_pkg::K_OCT, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_RHEX: begin
               if (stt_pkg::is_hexdig(c)) len_in = linc(len_ff);
               else begin
                  tk[0] = '{stt_pkg::K_HEX, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_DEC: begin
               if (stt_pkg::is_digit(c)) len_in = linc(len_ff);
               else if (c == ".") mode_in = stt_pkg::M_DECDOT;
               else begin
                  tk[0] = '{stt_pkg::K_DECIMAL, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_DECDOT: begin
               if (stt_pkg::is_digit(c)) begin
                  len_in = linc(linc(len_ff));
                  mode_in = stt_pkg::M_FRAC;
               end else begin
                  tk[0] = '{stt_pkg::K_DECIMAL, begin_ff, len_ff, line_ff, 1'b0};
                  tk[1] = '{stt_pkg::K_DOT, dot_off, 1, line_ff, 1'b0};
                  n = 2'd2;
                  again = 1'b1;
               end
            end
            stt_pkg::M_FRAC: begin
               if (stt_pkg::is_digit(c)) len_in = linc(len_ff);
               else begin
                  tk[0] = '{stt_pkg::K_DECIMAL, begin_ff, len_ff, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end
            end
            stt_pkg::M_STRING: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  if (c == "\n") line_in = (line_ff == LineMax) ? line_ff : line_ff + 1'b1;
                  len_in = linc(len_ff);
               end else if (c == (dquote_ff ? 8'h22 : 8'h27)) begin
                  len_in = linc(len_ff);
                  tk[0] = '{stt_pkg::K_STR, begin_ff, linc(len_ff), line_ff, 1'b0};
                  n = 2'd1;
                  mode_in = stt_pkg::M_IDLE;
               end else if (c == "\\") begin
                  esc_in = 1'b1;
                  len_in = linc(len_ff);
               end else if (c == "\n") begin
                  tk[0] = '{stt_pkg::K_ERR_STR, begin_ff, 0, line_ff, 1'b0}; n = 2'd1;
                  again = 1'b1;
               end else len_in = linc(len_ff);
            end
            stt_pkg::M_OPER: begin
               if (pk[stt_pkg::KindWidth]) begin
                  tk[0] = '{pk[stt_pkg::KindWidth-1:0], begin_ff, 2, line_ff, 1'b0};
                  n = 2'd1;
                  mode_in = stt_pkg::M_IDLE;
               end else begin
                  tk[0] = '{stt_pkg::lone_kind(held_ff), begin_ff, 1, line_ff, 1'b0};
                  n = 2'd1;
                  again = 1'b1;
               end
            end
            default: again = 1'b1;
         endcase

         // start of a new token from this byte
         if (again) begin
            mode_in = stt_pkg::M_IDLE;
            if (c == " " || c == "\t" || c == "\r") begin
               mode_in = stt_pkg::M_IDLE;
            end else if (c == "\n") begin
               line_in = (line_ff == LineMax) ? line_ff : line_ff + 1'b1;
            end else begin
               begin_in = pos_ff;
               len_in = stt_pkg::LengthWidth'(1);
               if (c == "/") mode_in = stt_pkg::M_SLASH;
               else if (stt_pkg::is_letter(c) || c == "_") begin
                  chars_in[7:0] = c;
                  mode_in = (c == "_") ? stt_pkg::M_UNDER : stt_pkg::M_WORD;
               end else if (stt_pkg::is_digit(c)) begin
                  mode_in = (c == "0") ? stt_pkg::M_ZERO : stt_pkg::M_DEC;
               end else if (c == 8'h22 || c == 8'h27) begin
                  dquote_in = (c == 8'h22);
                  esc_in = 1'b0;
                  mode_in = stt_pkg::M_STRING;
               end else if (c == ":" || c == "+" || c == "-" || c == "!" || c == "=" ||
                            c == "<" || c == ">" || c == "&" || c == "|") begin
                  held_in = c;
                  mode_in = stt_pkg::M_OPER;
               end else if (sk[stt_pkg::KindWidth]) begin
                  tk[n] = '{sk[stt_pkg::KindWidth-1:0], pos_ff, 1, line_ff, 1'b0};
                  n = n + 2'd1;
               end else begin
                  tk[n] = '{stt_pkg::K_ERR_CHAR, pos_ff, 0, line_ff, 1'b0};
                  n = n + 2'd1;
               end
            end
         end
      end

      if (n != 2'd0) tk[n - 2'd1].last = 1'b1;
      batch.count = n;
      batch.t0 = tk[0];
      batch.t1 = tk[1];
      batch.t2 = tk[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stt_pkg::M_IDLE;
         begin_ff <= '0;
         pos_ff <= '0;
         len_ff <= '0;
         line_ff <= stt_pkg::LineWidth'(1);
         held_ff <= '0;
         dquote_ff <= 1'b0;
         esc_ff <= 1'b0;
      end else if (step) begin
         mode_ff <= mode_in;
         begin_ff <= begin_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         line_ff <= line_in;
         held_ff <= held_in;
         dquote_ff <= dquote_in;
         esc_ff <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) chars_ff <= chars_in;
   end

endmodule

// ===== rtl/stt_queue.sv =====
// two-entry queue of token batches between scanner and output sequencer
module stt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stt_pkg::batch_type push_data,
   input  logic               pop,
   output logic               not_empty,
   output logic               not_full,
   output stt_pkg::batch_type head
);

   stt_pkg::batch_type mem_ff [2];
   logic               wp_ff, wp_in;
   logic               rp_ff, rp_in;
   logic [1:0]         cnt_ff, cnt_in;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign not_empty = (cnt_ff != 2'd0);
   assign not_full = (cnt_ff != 2'd2);
   assign head = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

// ===== rtl/stt_emit.sv =====
// back end: walks the tokens of the head batch onto the output register
module stt_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  stt_pkg::batch_type  head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output stt_pkg::token_type  out_token
);

   logic [1:0]         idx_ff, idx_in;
   logic               vld_ff, vld_in;
   stt_pkg::token_type tok_ff, tok_in;
   logic               load;
   stt_pkg::token_type cur;

   always_comb begin
      unique case (idx_ff)
         2'd0: cur = head.t0;
         2'd1: cur = head.t1;
         default: cur = head.t2;
      endcase
      load = (!vld_ff || out_ready) && head_valid && (head.count != 2'd0);
      pop = head_valid && ((head.count == 2'd0) ||
                           (load && (idx_ff + 2'd1 == head.count)));
      idx_in = pop ? 2'd0 : (load ? idx_ff + 2'd1 : idx_ff);
      vld_in = load ? 1'b1 : (out_ready ? 1'b0 : vld_ff);
      tok_in = load ? cur : tok_ff;
   end

   assign out_valid = vld_ff;
   assign out_token = tok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Source text tokenizer.
// Input stream req_: one character word per transfer; req_tdata holds the
// character, req_tlast marks end of text (a zero character also ends it).
// Output stream rsp_: one token per word; rsp_tdata carries kind, start,
// length and line, rsp_tlast marks the last token made by one input word.
// The scanner takes one character per cycle while the queue is not full and
// writes the 0 to 3 tokens it makes into a two-entry queue; the output
// sequencer sends one token per cycle while rsp_tready is high, from the
// queue head through an output register. A token passes through a queue entry
// and the output register before it shows on rsp_. A word that makes several
// tokens keeps the output busy for each of them, so bursts of operators can fill
// the queue and drop req_tready.
// Reset clears scanner state (line 1, offset 0) and empties the queue.
// When rsp_tready is low the output holds; req_tready falls once both queue
// entries are filled.
// End of text flushes any open token, sends EOF and rewinds the scanner.
module source_text_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // token_kind[6:0], token_start[38:7],
                                    // token_length[54:39], token_line[78:55], zero
   output logic        rsp_tlast    // last_of_run
);

   stt_pkg::batch_type batch;
   stt_pkg::batch_type head;
   stt_pkg::token_type tok;
   logic               step;
   logic               not_empty;
   logic               not_full;
   logic               pop;

   assign req_tready = not_full;
   assign step = req_tvalid && not_full;

   stt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .batch       (batch)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (batch),
      .pop       (pop),
      .not_empty (not_empty),
      .not_full  (not_full),
      .head      (head)
   );

   stt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_token  (tok)
   );

   assign rsp_tdata = {1'b0, tok.line, tok.length, tok.start, tok.kind};
   assign rsp_tlast = tok.last;

endmodule

// ===== rtl/stt_check.sv =====
module stt_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output changed under stall");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:0] <= stt_pkg::K_ERR_CHAR)
      else $error("token kind out of range");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6:0] == stt_pkg::K_END |-> rsp_tlast)
      else $error("eof not last of run");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[6:0] == stt_pkg::K_END ||
                     rsp_tdata[6:0] == stt_pkg::K_ERR_STR ||
                     rsp_tdata[6:0] == stt_pkg::K_ERR_CHAR) |-> rsp_tdata[54:39] == '0)
      else $error("error or eof with nonzero length");

   a_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[78:55] != '0)
      else $error("line zero");

endmodule

bind source_text_tokenizer stt_check u_stt_check (.*);

// ===== bench/source_text_tokenizer_tb.sv =====
module source_text_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [stt_pkg::OffsetWidth-1:0] OffsetMax = '1;
   localparam logic [stt_pkg::LengthWidth-1:0] LengthMax = '1;
   localparam logic [stt_pkg::LineWidth-1:0]   LineMax   = '1;

   typedef struct {
      logic [7:0]                    text;
      logic                          eot;
      logic                          typed;   // final token kind given in the table
      logic [stt_pkg::KindWidth-1:0] kind;
   } text_item_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;

   text_item_type      text_items[$];
   stt_pkg::token_type tokens_due[$];
   string              snippets[$];
   int                 accepted;
   int                 errors;
   logic               sending_done;

   // scanner copy
   stt_pkg::mode_type               scan_state;
   logic [stt_pkg::OffsetWidth-1:0] tok_begin;
   logic [stt_pkg::OffsetWidth-1:0] byte_pos;
   logic [stt_pkg::LengthWidth-1:0] tok_len;
   logic [stt_pkg::LineWidth-1:0]   line_no;
   logic [7:0]                      word_buf[stt_pkg::WordDepth];
   logic [7:0]                      held;
   logic                            dquote;
   logic                            escaped;

   source_text_tokenizer DUT (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic void add_token(logic [stt_pkg::KindWidth-1:0] k,
                                     logic [stt_pkg::OffsetWidth-1:0] s,
                                     logic [stt_pkg::LengthWidth-1:0] n);
      stt_pkg::token_type t;
      t.kind = k;
      t.start = s;
      t.length = n;
      t.line = line_no;
      t.last = 1'b0;
      tokens_due.push_back(t);
   endfunction

   function automatic void bump_len();
      if (tok_len != LengthMax) tok_len = tok_len + 1'b1;
   endfunction

   function automatic void bump_line();
      if (line_no != LineMax) line_no = line_no + 1'b1;
   endfunction

   function automatic logic [stt_pkg::OffsetWidth-1:0] step_offset(
      logic [stt_pkg::OffsetWidth-1:0] v);
      return (v == OffsetMax) ? v : v + 1'b1;
   endfunction

   function automatic logic [stt_pkg::KindWidth-1:0] keyword_code();
      string s;
      s = "";
      if (tok_len > stt_pkg::WordDepth) return stt_pkg::K_ID;
      for (int i = 0; i < tok_len; i++) s = {s, string'(word_buf[i])};
      case (s)
         "as": return stt_pkg::K_AS;
         "def", "define": return stt_pkg::K_DEF;
         "enum": return stt_pkg::K_ENUM;
         "else": return stt_pkg::K_ELSE;
         "u8", "i8", "u16", "u32", "u64", "i16", "i32", "i64", "f32", "f64":
            return stt_pkg::K_WIDTHWORD;
         "false": return stt_pkg::K_FALSE;
         "form": return stt_pkg::K_FORM;
         "global": return stt_pkg::K_GLOBAL;
         "include": return stt_pkg::K_INCLUDE;
         "log": return stt_pkg::K_LOG;
         "none", "NONE": return stt_pkg::K_NONE;
         "op", "operation": return stt_pkg::K_OP;
         "or": return stt_pkg::K_OR;
         "obj", "object": return stt_pkg::K_OBJ;
         "parent": return stt_pkg::K_PARENT;
         "pair": return stt_pkg::K_PAIR;
         "pilot": return stt_pkg::K_PILOT;
         "private": return stt_pkg::K_PRIVATE;
         "public": return stt_pkg::K_PUBLIC;
         "return": return stt_pkg::K_RETURN;
         "self": return stt_pkg::K_SELF;
         "this": return stt_pkg::K_THIS;
         "true": return stt_pkg::K_TRUE;
         "when": return stt_pkg::K_WHEN;
         "while": return stt_pkg::K_WHILE;
         "write": return stt_pkg::K_WRITE;
         default: return stt_pkg::K_ID;
      endcase
   endfunction

   // -1 when the two chars do not form an operator
   function automatic int two_char_op(logic [7:0] h, logic [7:0] c);
      case (h)
         ":": if (c == ":") return stt_pkg::K_DCOLON;
         "+": if (c == "+") return stt_pkg::K_PLUSPLUS;
              else if (c == "=") return stt_pkg::K_PLUSSET;
         "-": if (c == ">") return stt_pkg::K_ARROW;
              else if (c == "-") return stt_pkg::K_MINUSMINUS;
              else if (c == "=") return stt_pkg::K_MINUSSET;
         "!": if (c == "=") return stt_pkg::K_NOTEQ;
         "=": if (c == "=") return stt_pkg::K_EQUALS2;
         "<": if (c == "=") return stt_pkg::K_LESSEQ;
              else if (c == "-") return stt_pkg::K_LARROW;
         ">": if (c == "=") return stt_pkg::K_MOREEQ;
         "&": if (c == "&") return stt_pkg::K_AMP2;
         "|": if (c == "|") return stt_pkg::K_PIPE2;
         default: ;
      endcase
      return -1;
   endfunction

   function automatic logic [stt_pkg::KindWidth-1:0] one_char_op(logic [7:0] h);
      case (h)
         ":": return stt_pkg::K_COLON;
         "+": return stt_pkg::K_ADD;
         "-": return stt_pkg::K_SUB;
         "!": return stt_pkg::K_BANG;
         "=": return stt_pkg::K_EQUALS;
         "<": return stt_pkg::K_LESS;
         ">": return stt_pkg::K_MORE;
         "&": return stt_pkg::K_AMP;
         "|": return stt_pkg::K_PIPE;
         default: return stt_pkg::K_ERR_CHAR;
      endcase
   endfunction

   function automatic int punct_op(logic [7:0] c);
      case (c)
         "(": return stt_pkg::K_LPAREN;
         ")": return stt_pkg::K_RPAREN;
         "[": return stt_pkg::K_LSQ;
         "]": return stt_pkg::K_RSQ;
         "{": return stt_pkg::K_LCURL;
         "}": return stt_pkg::K_RCURL;
         ".": return stt_pkg::K_DOT;
         ",": return stt_pkg::K_COMMA;
         "*": return stt_pkg::K_ASTER;
         "%": return stt_pkg::K_PERCENT;
         "?": return stt_pkg::K_QMARK;
         "$": return stt_pkg::K_DOLLAR;
         "^": return stt_pkg::K_CARET;
         "@": return stt_pkg::K_AT;
         default: return -1;
      endcase
   endfunction

   function automatic logic [stt_pkg::OffsetWidth-1:0] period_offset();
      if (byte_pos == OffsetMax || byte_pos == 0) return byte_pos;
      return byte_pos - 1'b1;
   endfunction

   function automatic void clear_scanner();
      scan_state = stt_pkg::M_IDLE;
      tok_begin = '0;
      byte_pos = '0;
      tok_len = '0;
      line_no = 1;
      held = '0;
      dquote = 1'b0;
      escaped = 1'b0;
   endfunction

   function automatic void open_token(logic [7:0] c, logic [stt_pkg::OffsetWidth-1:0] cur);
      int k;
      scan_state = stt_pkg::M_IDLE;
      if (c == " " || c == 8'h09 || c == 8'h0d) return;
      if (c == 8'h0a) begin
         bump_line();
         return;
      end
      tok_begin = cur;
      tok_len = 1;
      if (c == "/") begin
         scan_state = stt_pkg::M_SLASH;
      end else if (alpha(c) || c == "_") begin
         word_buf[0] = c;
         scan_state = (c == "_") ? stt_pkg::M_UNDER : stt_pkg::M_WORD;
      end else if (numeral(c)) begin
         scan_state = (c == "0") ? stt_pkg::M_ZERO : stt_pkg::M_DEC;
      end else if (c == "\"" || c == "'") begin
         dquote = (c == "\"");
         escaped = 1'b0;
         scan_state = stt_pkg::M_STRING;
      end else if (c inside {":", "+", "-", "!", "=", "<", ">", "&", "|"}) begin
         held = c;
         scan_state = stt_pkg::M_OPER;
      end else begin
         k = punct_op(c);
         if (k >= 0) add_token(k[stt_pkg::KindWidth-1:0], cur, 1);
         else add_token(stt_pkg::K_ERR_CHAR, cur, 0);
      end
   endfunction

   function automatic void open_radix(stt_pkg::mode_type m,
                                      logic [stt_pkg::OffsetWidth-1:0] cur);
      scan_state = m;
      tok_begin = step_offset(cur);
      tok_len = 0;
   endfunction

   // a closed token hands its byte back to the idle scan (rescan = 1);
   // keep means the byte is scanned again in the mode just chosen
   function automatic void scan_char(logic [7:0] c, logic [stt_pkg::OffsetWidth-1:0] cur);
      logic rescan;
      logic keep;
      int   k;
      rescan = 1'b1;
      while (rescan) begin
         rescan = 1'b0;
         keep = 1'b0;
         case (scan_state)
            stt_pkg::M_SLASH:
               if (c == "/") scan_state = stt_pkg::M_LINECMT;
               else if (c == "*") scan_state = stt_pkg::M_BLOCK;
               else begin
                  add_token(stt_pkg::K_SLASH, tok_begin, 1);
                  rescan = 1'b1;
               end
            stt_pkg::M_LINECMT:
               if (c == 8'h0a) begin
                  bump_line();
                  scan_state = stt_pkg::M_IDLE;
               end
            stt_pkg::M_BLOCK, stt_pkg::M_BLOCKSTAR:
               if (c == "/" && scan_state == stt_pkg::M_BLOCKSTAR) begin
                  scan_state = stt_pkg::M_IDLE;
               end else begin
                  if (c == 8'h0a) bump_line();
                  scan_state = (c == "*") ? stt_pkg::M_BLOCKSTAR : stt_pkg::M_BLOCK;
               end
            stt_pkg::M_UNDER:
               if (alpha(c) || c == "_") begin
                  scan_state = stt_pkg::M_WORD;
                  rescan = 1'b1;
                  keep = 1'b1;
               end else begin
                  add_token(stt_pkg::K_UNDERSCORE, tok_begin, 1);
                  rescan = 1'b1;
               end
            stt_pkg::M_WORD:
               if (alpha(c) || c == "_" || numeral(c)) begin
                  if (tok_len < stt_pkg::WordDepth) word_buf[tok_len] = c;
                  bump_len();
               end else begin
                  add_token(keyword_code(), tok_begin, tok_len);
                  rescan = 1'b1;
               end
            stt_pkg::M_ZERO:
               if (c == "b") open_radix(stt_pkg::M_RBIN, cur);
               else if (c == "c") open_radix(stt_pkg::M_ROCT, cur);
               else if (c == "x") open_radix(stt_pkg::M_RHEX, cur);
               else begin
                  scan_state = stt_pkg::M_DEC;
                  rescan = 1'b1;
                  keep = 1'b1;
               end
            stt_pkg::M_RBIN:
               if (c == "0" || c == "1") bump_len();
               else begin
                  add_token(stt_pkg::K_BIN, tok_begin, tok_len);
                  rescan = 1'b1;
               end
            stt_pkg::M_ROCT:
               if (c >= "0" && c <= "7") bump_len();
               else begin
                  add_token(stt_pkg::K_OCT, tok_begin, tok_len);
                  rescan = 1'b1;
               end
            stt_pkg::M_RHEX:
               if (numeral(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")) bump_len();
               else begin
                  add_token(stt_pkg::K_HEX, tok_begin, tok_len);
                  rescan = 1'b1;
               end
            stt_pkg::M_DEC:
               if (numeral(c)) bump_len();
               else if (c == ".") scan_state = stt_pkg::M_DECDOT;
               else begin
                  add_token(stt_pkg::K_DECIMAL, tok_begin, tok_len);
                  rescan = 1'b1;
               end
            stt_pkg::M_DECDOT:
               if (numeral(c)) begin
                  bump_len();
                  bump_len();
                  scan_state = stt_pkg::M_FRAC;
               end else begin
                  add_token(stt_pkg::K_DECIMAL, tok_begin, tok_len);
                  add_token(stt_pkg::K_DOT, period_offset(), 1);
                  rescan = 1'b1;
               end
            stt_pkg::M_FRAC:
               if (numeral(c)) bump_len();
               else begin
                  add_token(stt_pkg::K_DECIMAL, tok_begin, tok_len);
                  rescan = 1'b1;
               end
            stt_pkg::M_STRING:
               if (escaped) begin
                  escaped = 1'b0;
                  if (c == 8'h0a) bump_line();
                  bump_len();
               end else if (c == (dquote ? 8'h22 : 8'h27)) begin
                  bump_len();
                  add_token(stt_pkg::K_STR, tok_begin, tok_len);
                  scan_state = stt_pkg::M_IDLE;
               end else if (c == "\\") begin
                  escaped = 1'b1;
                  bump_len();
               end else if (c == 8'h0a) begin
                  add_token(stt_pkg::K_ERR_STR, tok_begin, 0);
                  rescan = 1'b1;
               end else begin
                  bump_len();
               end
            stt_pkg::M_OPER: begin
               k = two_char_op(held, c);
               if (k >= 0) begin
                  add_token(k[stt_pkg::KindWidth-1:0], tok_begin, 2);
                  scan_state = stt_pkg::M_IDLE;
               end else begin
                  add_token(one_char_op(held), tok_begin, 1);
                  rescan = 1'b1;
               end
            end
            default: open_token(c, cur);
         endcase
         if (rescan && !keep) scan_state = stt_pkg::M_IDLE;
      end
   endfunction

   function automatic void close_text();
      case (scan_state)
         stt_pkg::M_SLASH: add_token(stt_pkg::K_SLASH, tok_begin, 1);
         stt_pkg::M_UNDER: add_token(stt_pkg::K_UNDERSCORE, tok_begin, 1);
         stt_pkg::M_WORD: add_token(keyword_code(), tok_begin, tok_len);
         stt_pkg::M_ZERO, stt_pkg::M_DEC, stt_pkg::M_FRAC:
            add_token(stt_pkg::K_DECIMAL, tok_begin, tok_len);
         stt_pkg::M_RBIN: add_token(stt_pkg::K_BIN, tok_begin, tok_len);
         stt_pkg::M_ROCT: add_token(stt_pkg::K_OCT, tok_begin, tok_len);
         stt_pkg::M_RHEX: add_token(stt_pkg::K_HEX, tok_begin, tok_len);
         stt_pkg::M_DECDOT: begin
            add_token(stt_pkg::K_DECIMAL, tok_begin, tok_len);
            add_token(stt_pkg::K_DOT, period_offset(), 1);
         end
         stt_pkg::M_STRING: add_token(stt_pkg::K_ERR_STR, tok_begin, 0);
         stt_pkg::M_OPER: add_token(one_char_op(held), tok_begin, 1);
         default: ;
      endcase
      add_token(stt_pkg::K_END, byte_pos, 0);
      clear_scanner();
   endfunction

   function automatic void predict_tokens(text_item_type it);
      int prior_count;
      prior_count = tokens_due.size();
      if (it.eot || it.text == 8'h00) begin
         close_text();
      end else begin
         scan_char(it.text, byte_pos);
         byte_pos = step_offset(byte_pos);
      end
      if (tokens_due.size() > prior_count) begin
         tokens_due[$].last = 1'b1;
         if (it.typed) tokens_due[$].kind = it.kind;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_item(logic [7:0] c, logic e, logic t = 1'b0,
                                    logic [stt_pkg::KindWidth-1:0] k = stt_pkg::K_ID);
      text_item_type it;
      it.text = c;
      it.eot = e;
      it.typed = t;
      it.kind = k;
      text_items.push_back(it);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
   endfunction

   // directed table, then random source text
   function automatic void build_stimulus();
      int r;
      string sep;
      add_item(8'h00, 1'b1, 1'b1, stt_pkg::K_END);       // eof right after reset
      add_item("0", 1'b0);
      add_item("x", 1'b0);
      add_item("q", 1'b1, 1'b1, stt_pkg::K_END);         // empty hex then eof
      add_item("@", 1'b0, 1'b1, stt_pkg::K_AT);
      add_item(8'hff, 1'b0, 1'b1, stt_pkg::K_ERR_CHAR);
      add_item("_", 1'b0);
      add_item(" ", 1'b0, 1'b1, stt_pkg::K_UNDERSCORE);
      add_item("1", 1'b0);
      add_item(".", 1'b0);
      add_item(")", 1'b0, 1'b1, stt_pkg::K_RPAREN);       // decimal, dot, paren
      add_item(8'h22, 1'b0);
      add_item("a", 1'b0);
      add_item(8'h0a, 1'b0, 1'b1, stt_pkg::K_ERR_STR);    // newline inside a string
      add_item("/", 1'b0);
      add_item("*", 1'b0);
      add_item(8'h0a, 1'b0);
      add_item(8'h00, 1'b0, 1'b1, stt_pkg::K_END);        // end inside block comment
      add_item(8'h27, 1'b0);
      add_item("\\", 1'b0);
      add_item(8'h80, 1'b1, 1'b1, stt_pkg::K_END);        // end inside a string
      add_item("<", 1'b0);
      add_item("-", 1'b0, 1'b1, stt_pkg::K_LARROW);
      add_item("7", 1'b0);
      add_item(".", 1'b1, 1'b1, stt_pkg::K_END);

      snippets = '{"as", "def", "define", "enum", "else", "u8", "i8", "u16", "u32", "u64",
                   "i16", "i32", "i64", "f32", "f64", "false", "form", "global", "include",
                   "log", "none", "NONE", "op", "operation", "or", "obj", "object", "parent",
                   "pair", "pilot", "private", "public", "return", "self", "this", "true",
                   "when", "while", "write", "x", "alpha9", "a_very_long_name", "operations",
                   "_k", "0b1012", "0c778", "0xfAg", "0", "123", "4.56", "7.", "0b", "0c",
                   "\"hi\\\"x\"", "'ab'", "\"a\\\nb\"", "'q\n", "(", ")", "[", "]", "{", "}",
                   ".", ",", "::", ":", "++", "+=", "+", "->", "--", "-=", "-", "*", "/", "%",
                   "_", "?", "$", "^", "!=", "!", "==", "=", "<=", "<-", "<", ">=", ">", "@",
                   "&&", "&", "||", "|", "// note\n", "/* a * b\n*/", "/**/", "#", "~"};
      while (text_items.size() < 278) begin
         r = $urandom_range(0, 99);
         if (r < 8) add_item(8'($urandom_range(1, 255)), 1'b0);
         else if (r < 10) add_item(8'($urandom_range(0, 255)), 1'b1);
         else if (r < 11) add_item(8'h00, 1'b0);
         else begin
            add_text(snippets[$urandom_range(0, snippets.size() - 1)]);
            r = $urandom_range(0, 9);
            if (r < 5) sep = " ";
            else if (r < 6) sep = "\t";
            else if (r < 7) sep = "\r\n";
            else if (r < 8) sep = "\n";
            else sep = "";
            add_text(sep);
         end
      end
      add_item(8'h00, 1'b1);
   endfunction

   initial begin
      int gap;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      errors = 0;
      accepted = 0;
      sending_done = 1'b0;
      clear_scanner();
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < text_items.size(); i++) begin
         // every fifth stretch of 30 words goes without gaps
         gap = ((i / 30) % 5 == 2) ? 0 : pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= text_items[i].text;
         req_tlast <= text_items[i].eot;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_tokens(text_items[accepted]);
         accepted <= accepted + 1;
      end
   end

   // receiver stalls
   initial begin
      int hold;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      stt_pkg::token_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tokens_due.size() == 0) begin
            $display("%t: unexpected token word %h last %b", $realtime, rsp_tdata, rsp_tlast);
            errors <= errors + 1;
         end else begin
            want = tokens_due.pop_front();
            if (rsp_tdata[6:0] !== want.kind || rsp_tdata[38:7] !== want.start ||
                rsp_tdata[54:39] !== want.length || rsp_tdata[78:55] !== want.line ||
                rsp_tlast !== want.last) begin
               $display("%t: token mismatch expected kind %0d start %0d len %0d line %0d last %b",
                        $realtime, want.kind, want.start, want.length, want.line, want.last);
               $display("%t:                actual   kind %0d start %0d len %0d line %0d last %b",
                        $realtime, rsp_tdata[6:0], rsp_tdata[38:7], rsp_tdata[54:39],
                        rsp_tdata[78:55], rsp_tlast);
               errors <= errors + 1;
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      wait (tokens_due.size() == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && tokens_due.size() == 0) begin
         $display("** source_text_tokenizer: PASSED **");
      end else begin
         $display("** source_text_tokenizer: FAILED **");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("** source_text_tokenizer: FAILED **");
      $finish;
   end

endmodule
